/* src/mrce_pkg.sv */
// Shared types and constants for the matrix row/column editor.
// No dependencies; imported by mrce_core, matrix_row_column_editor_unit and tb_top.
package mrce_pkg;

	// Fixed field widths of the stream payload
	localparam int IDX_W       = 4;
	localparam int VALUE_W     = 32;
	localparam int STATUS_W    = 2;
	localparam int ACTION_W    = 3;
	localparam int IN_TDATA_W  = 48;
	localparam int OUT_TDATA_W = 48;

	// Defaults for the top-level parameters
	localparam int MAX_DIM_DEF    = 8;
	localparam int DATA_WIDTH_DEF = 32;

	typedef enum logic [ACTION_W-1:0] {
		ACT_SET_SIZE = 3'd0,
		ACT_WRITE    = 3'd1,
		ACT_READ     = 3'd2,
		ACT_DEL_ROW  = 3'd3,
		ACT_DEL_COL  = 3'd4,
		ACT_INS_ROW  = 3'd5,
		ACT_INS_COL  = 3'd6
	} action_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_DONE    = 2'd0,
		ST_RANGE   = 2'd1,
		ST_REFUSED = 2'd2
	} status_t;

	// One input transaction, unpacked
	typedef struct packed {
		logic [ACTION_W-1:0]       action;
		logic [IDX_W-1:0]          row_index;
		logic [IDX_W-1:0]          col_index;
		logic [IDX_W-1:0]          new_size;
		logic signed [VALUE_W-1:0] data_value;
	} item_t;

	// One result transaction, unpacked
	typedef struct packed {
		logic signed [VALUE_W-1:0] read_value;
		status_t                   status;
		logic [IDX_W-1:0]          rows_now;
		logic [IDX_W-1:0]          cols_now;
	} result_t;

endpackage

/* src/mrce_core.sv */
// Cell table, row/column counts and the combinational action logic.
// Depends on mrce_pkg.
module mrce_core #(
	parameter int MAX_DIM    = 8,
	parameter int DATA_WIDTH = 32
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,      // commit the action of item
	input  mrce_pkg::item_t   item,
	output mrce_pkg::result_t result
);
	import mrce_pkg::*;

	localparam int CNT_W = $clog2(MAX_DIM + 1);
	localparam int POS_W = $clog2(MAX_DIM);
	localparam int CMP_W = (CNT_W > IDX_W) ? CNT_W : IDX_W;

	logic [DATA_WIDTH-1:0] cell_q [MAX_DIM][MAX_DIM];
	logic [CNT_W-1:0]      row_count_q;
	logic [CNT_W-1:0]      col_count_q;

	logic [CMP_W-1:0]      ri, ci, sz, rc, cc, dim_max;
	logic signed [DATA_WIDTH-1:0] fill;
	logic [DATA_WIDTH-1:0] rd_data;
	logic                  do_clear, do_write, do_del_row, do_del_col;
	logic                  do_ins_row, do_ins_col, rd_hit;
	status_t               status;
	logic [CNT_W-1:0]      rows_nx, cols_nx;

	// Common-width views of indices and counts
	assign ri      = CMP_W'(item.row_index);
	assign ci      = CMP_W'(item.col_index);
	assign sz      = CMP_W'(item.new_size);
	assign rc      = CMP_W'(row_count_q);
	assign cc      = CMP_W'(col_count_q);
	assign dim_max = CMP_W'(MAX_DIM);
	assign fill    = DATA_WIDTH'(item.data_value);

	// Action decode and range checks
	always_comb begin
		do_clear   = 1'b0;
		do_write   = 1'b0;
		do_del_row = 1'b0;
		do_del_col = 1'b0;
		do_ins_row = 1'b0;
		do_ins_col = 1'b0;
		rd_hit     = 1'b0;
		status     = ST_DONE;
		rows_nx    = row_count_q;
		cols_nx    = col_count_q;
		unique case (action_t'(item.action))
			ACT_SET_SIZE: begin
				if (sz == '0 || sz > dim_max) begin
					status = ST_RANGE;
				end else begin
					do_clear = 1'b1;
					rows_nx  = CNT_W'(sz);
					cols_nx  = CNT_W'(sz);
				end
			end
			ACT_WRITE, ACT_READ: begin
				if (ri >= rc || ci >= cc) begin
					status = ST_RANGE;
				end else if (action_t'(item.action) == ACT_WRITE) begin
					do_write = 1'b1;
				end else begin
					rd_hit = 1'b1;
				end
			end
			ACT_DEL_ROW: begin
				if (ri >= rc) begin
					status = ST_RANGE;
				end else begin
					do_del_row = 1'b1;
					rows_nx    = row_count_q - CNT_W'(1);
				end
			end
			ACT_DEL_COL: begin
				if (ci >= cc) begin
					status = ST_RANGE;
				end else begin
					do_del_col = 1'b1;
					cols_nx    = col_count_q - CNT_W'(1);
				end
			end
			ACT_INS_ROW: begin
				if (ri > rc) begin
					status = ST_RANGE;
				end else if (rc >= dim_max) begin
					status = ST_REFUSED;
				end else begin
					do_ins_row = 1'b1;
					rows_nx    = row_count_q + CNT_W'(1);
				end
			end
			ACT_INS_COL: begin
				if (ci > cc) begin
					status = ST_RANGE;
				end else if (cc >= dim_max) begin
					status = ST_REFUSED;
				end else begin
					do_ins_col = 1'b1;
					cols_nx    = col_count_q + CNT_W'(1);
				end
			end
			default: begin
				status = ST_REFUSED;
			end
		endcase
	end

	// Per-cell next value: itself, a neighbor, the fill value or zero
	for (genvar r = 0; r < MAX_DIM; r++) begin : g_row
		for (genvar c = 0; c < MAX_DIM; c++) begin : g_col
			logic [DATA_WIDTH-1:0] from_below, from_above, from_right, from_left;
			logic [DATA_WIDTH-1:0] cell_d;
			logic [CMP_W-1:0]      rpos, cpos;

			assign rpos = CMP_W'(r);
			assign cpos = CMP_W'(c);

			if (r < MAX_DIM - 1) begin : g_below
				assign from_below = cell_q[r+1][c];
			end else begin : g_below_edge
				assign from_below = cell_q[r][c];
			end
			if (r > 0) begin : g_above
				assign from_above = cell_q[r-1][c];
			end else begin : g_above_edge
				assign from_above = cell_q[r][c];
			end
			if (c < MAX_DIM - 1) begin : g_right
				assign from_right = cell_q[r][c+1];
			end else begin : g_right_edge
				assign from_right = cell_q[r][c];
			end
			if (c > 0) begin : g_left
				assign from_left = cell_q[r][c-1];
			end else begin : g_left_edge
				assign from_left = cell_q[r][c];
			end

			always_comb begin
				priority if (do_clear) begin
					cell_d = '0;
				end else if (do_write && rpos == ri && cpos == ci) begin
					cell_d = fill;
				end else if (do_del_row && rpos >= ri) begin
					cell_d = from_below;
				end else if (do_del_col && cpos >= ci) begin
					cell_d = from_right;
				end else if (do_ins_row && rpos == ri) begin
					cell_d = fill;
				end else if (do_ins_row && rpos > ri) begin
					cell_d = from_above;
				end else if (do_ins_col && cpos == ci) begin
					cell_d = fill;
				end else if (do_ins_col && cpos > ci) begin
					cell_d = from_left;
				end else begin
					cell_d = cell_q[r][c];
				end
			end

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					cell_q[r][c] <= '0;
				end else if (en) begin
					cell_q[r][c] <= cell_d;
				end
			end
		end
	end

	// Counts
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_count_q <= '0;
			col_count_q <= '0;
		end else if (en) begin
			row_count_q <= rows_nx;
			col_count_q <= cols_nx;
		end
	end

	// Read port and result
	assign rd_data = cell_q[item.row_index[POS_W-1:0]][item.col_index[POS_W-1:0]];

	always_comb begin
		result.read_value = rd_hit ? VALUE_W'($signed(rd_data)) : '0;
		result.status     = status;
		result.rows_now   = IDX_W'(rows_nx);
		result.cols_now   = IDX_W'(cols_nx);
	end

endmodule

/* src/matrix_row_column_editor_unit.sv */
// Matrix row/column editor: top level with stream ports, input and result registers.
// Depends on mrce_pkg and mrce_core.
//
// Holds a table of up to MAX_DIM x MAX_DIM signed words with separate row and
// column counts. Each input transaction carries one action (set size, write,
// read, delete row/column, insert row/column) and yields exactly one result
// transaction with status, read data and the counts after the action. Every
// action completes as its transaction moves from the input register into the
// result register, since each cell loads itself, a neighbor, the fill value or
// zero at once; one transaction is taken per clock while m_tready stays high.
// Each result transaction passes through the input register and then the
// result register, which loads when the table commits the action.
// While a result waits, one further input transaction is still taken into the
// input register; the input then stalls until the result drains. Reset clears
// the table and both counts immediately.
module matrix_row_column_editor_unit #(
	parameter int MAX_DIM    = mrce_pkg::MAX_DIM_DEF,
	parameter int DATA_WIDTH = mrce_pkg::DATA_WIDTH_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	// action[2:0], row_index[6:3], col_index[10:7], new_size[14:11],
	// data_value[46:15], zero pad[47]
	input  logic [mrce_pkg::IN_TDATA_W-1:0]  s_tdata,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	// read_value[31:0], status[33:32], rows_now[37:34], cols_now[41:38],
	// zero pad[47:42]
	output logic [mrce_pkg::OUT_TDATA_W-1:0] m_tdata,
	output logic                             m_tvalid,
	input  logic                             m_tready
);
	import mrce_pkg::*;

	item_t   item_in;
	item_t   item_s1;
	logic    valid_s1;
	logic    advance;
	result_t res_d;
	result_t res_q;
	logic    out_valid_q;

	// Unpack input transaction
	always_comb begin
		item_in.action     = s_tdata[2:0];
		item_in.row_index  = s_tdata[6:3];
		item_in.col_index  = s_tdata[10:7];
		item_in.new_size   = s_tdata[14:11];
		item_in.data_value = s_tdata[46:15];
	end

	// Item moves to the result register when that slot is free or draining
	assign advance  = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready = !valid_s1 || advance;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tvalid && s_tready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			item_s1 <= item_in;
		end
	end

	// Table and action logic
	mrce_core #(
		.MAX_DIM    (MAX_DIM),
		.DATA_WIDTH (DATA_WIDTH)
	) u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (advance),
		.item   (item_s1),
		.result (res_d)
	);

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= res_d;
		end
	end

	// Pack result transaction
	assign m_tvalid = out_valid_q;
	assign m_tdata  = {6'b0, res_q.cols_now, res_q.rows_now, res_q.status, res_q.read_value};

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 100ps
// Self-checking bench for matrix_row_column_editor_unit: directed and random table edits.
// Depends on mrce_pkg and the editor RTL; a local table model predicts every result.
module tb_top;
	import mrce_pkg::*;

	localparam int GRID_DIM = MAX_DIM_DEF;
	localparam logic [ACTION_W-1:0] OP_UNDEFINED = 3'd7;
	localparam int RANDOM_EDITS = 1000;
	localparam int HOLD_AT = 300;
	localparam int HOLD_LEN = 150;

	typedef struct {
		logic [ACTION_W-1:0]       op;
		logic [IDX_W-1:0]          row;
		logic [IDX_W-1:0]          col;
		logic [IDX_W-1:0]          size;
		logic signed [VALUE_W-1:0] value;
	} edit_t;

	typedef struct {
		logic signed [VALUE_W-1:0] rd;
		status_t                   st;
		logic [IDX_W-1:0]          nrows;
		logic [IDX_W-1:0]          ncols;
	} reply_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic [IN_TDATA_W-1:0] s_tdata = '0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [OUT_TDATA_W-1:0] m_tdata;
	logic m_tvalid;
	logic m_tready = 1'b0;

	// table model
	logic signed [VALUE_W-1:0] grid [GRID_DIM][GRID_DIM];
	logic [IDX_W-1:0] grid_rows = '0;
	logic [IDX_W-1:0] grid_cols = '0;

	edit_t pending_edits[$];
	reply_t expected_replies[$];
	edit_t offered;
	int mismatches = 0;
	int reply_no = 0;
	int unsigned cyc = 0;
	int hold_left = 0;
	wire calm = (cyc >= 600 && cyc < 1100);

	matrix_row_column_editor_unit u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tdata  (s_tdata),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tdata  (m_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready)
	);

	initial begin
		foreach (grid[i, j])
			grid[i][j] = '0;
	end

	initial begin
		forever #1 clk = ~clk;
	end

	always @(posedge clk) begin
		cyc <= cyc + 1;
	end

	// Apply one edit to the model table and return the result it should give
	function automatic reply_t apply_edit(edit_t e);
		reply_t r;
		int i;
		int j;
		r.rd = '0;
		r.st = ST_DONE;
		case (e.op)
			ACT_SET_SIZE: begin
				if (e.size == 0 || e.size > GRID_DIM) begin
					r.st = ST_RANGE;
				end else begin
					foreach (grid[a, b])
						grid[a][b] = '0;
					grid_rows = e.size;
					grid_cols = e.size;
				end
			end
			ACT_WRITE, ACT_READ: begin
				if (e.row >= grid_rows || e.col >= grid_cols)
					r.st = ST_RANGE;
				else if (e.op == ACT_WRITE)
					grid[e.row][e.col] = e.value;
				else
					r.rd = grid[e.row][e.col];
			end
			ACT_DEL_ROW: begin
				if (e.row >= grid_rows) begin
					r.st = ST_RANGE;
				end else begin
					for (i = int'(e.row); i + 1 < int'(grid_rows); i++)
						grid[i] = grid[i + 1];
					grid_rows--;
				end
			end
			ACT_DEL_COL: begin
				if (e.col >= grid_cols) begin
					r.st = ST_RANGE;
				end else begin
					for (i = 0; i < GRID_DIM; i++)
						for (j = int'(e.col); j + 1 < int'(grid_cols); j++)
							grid[i][j] = grid[i][j + 1];
					grid_cols--;
				end
			end
			ACT_INS_ROW: begin
				if (e.row > grid_rows) begin
					r.st = ST_RANGE;
				end else if (grid_rows >= GRID_DIM) begin
					r.st = ST_REFUSED;
				end else begin
					for (i = int'(grid_rows); i > int'(e.row); i--)
						grid[i] = grid[i - 1];
					for (j = 0; j < GRID_DIM; j++)
						grid[e.row][j] = e.value;
					grid_rows++;
				end
			end
			ACT_INS_COL: begin
				if (e.col > grid_cols) begin
					r.st = ST_RANGE;
				end else if (grid_cols >= GRID_DIM) begin
					r.st = ST_REFUSED;
				end else begin
					for (i = 0; i < GRID_DIM; i++) begin
						for (j = int'(grid_cols); j > int'(e.col); j--)
							grid[i][j] = grid[i][j - 1];
						grid[i][e.col] = e.value;
					end
					grid_cols++;
				end
			end
			default: r.st = ST_REFUSED;
		endcase
		r.nrows = grid_rows;
		r.ncols = grid_cols;
		return r;
	endfunction

	task automatic queue_edit(input logic [ACTION_W-1:0] op, input logic [IDX_W-1:0] row,
			input logic [IDX_W-1:0] col, input logic [IDX_W-1:0] size,
			input logic [VALUE_W-1:0] value);
		edit_t e;
		e.op = op;
		e.row = row;
		e.col = col;
		e.size = size;
		e.value = value;
		pending_edits.push_back(e);
	endtask

	task automatic flag_mismatch(input string what);
		mismatches++;
		$display("mismatch at reply %0d: %s", reply_no, what);
	endtask

	// Driver: offers queued edits, predicts each one as its transaction completes
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
		end else begin
			if (s_tvalid && s_tready)
				expected_replies.push_back(apply_edit(offered));
			if (!s_tvalid || s_tready) begin
				if (pending_edits.size() != 0 && (calm || $urandom_range(99) >= 28)) begin
					offered = pending_edits.pop_front();
					s_tdata <= {1'b0, offered.value, offered.size, offered.col, offered.row,
						offered.op};
					s_tvalid <= 1'b1;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// Monitor: random backpressure with one long hold-off, checks every result
	always @(posedge clk or negedge arst_n) begin
		reply_t want;
		if (!arst_n) begin
			m_tready <= 1'b0;
			hold_left <= 0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (expected_replies.size() == 0) begin
					flag_mismatch($sformatf("unexpected result %h", m_tdata));
				end else begin
					want = expected_replies.pop_front();
					if (m_tdata[31:0] !== want.rd)
						flag_mismatch($sformatf("read_value got %h want %h",
							m_tdata[31:0], want.rd));
					if (m_tdata[33:32] !== want.st)
						flag_mismatch($sformatf("status got %0d want %0d",
							m_tdata[33:32], want.st));
					if (m_tdata[37:34] !== want.nrows)
						flag_mismatch($sformatf("rows_now got %0d want %0d",
							m_tdata[37:34], want.nrows));
					if (m_tdata[41:38] !== want.ncols)
						flag_mismatch($sformatf("cols_now got %0d want %0d",
							m_tdata[41:38], want.ncols));
				end
				reply_no++;
			end
			if (hold_left > 0) begin
				hold_left <= hold_left - 1;
				m_tready <= 1'b0;
			end else if (cyc == HOLD_AT) begin
				hold_left <= HOLD_LEN;
				m_tready <= 1'b0;
			end else begin
				m_tready <= calm || $urandom_range(99) >= 28;
			end
		end
	end

	// Stimulus, reset and end of run
	initial begin
		int n;
		int pick;
		int g_rows;
		int g_cols;
		logic [ACTION_W-1:0] op;
		logic [IDX_W-1:0] row;
		logic [IDX_W-1:0] col;
		logic [IDX_W-1:0] size;

		// empty table: every access is out of range
		queue_edit(ACT_READ, 0, 0, 0, 0);
		queue_edit(ACT_DEL_ROW, 0, 0, 0, 0);
		queue_edit(ACT_DEL_COL, 0, 0, 0, 0);
		queue_edit(ACT_INS_ROW, 1, 0, 0, 0);
		// insert into an empty other dimension, then fill the first cell
		queue_edit(ACT_INS_ROW, 0, 0, 0, 5);
		queue_edit(ACT_INS_COL, 0, 0, 0, 32'h0000_1234);
		queue_edit(ACT_READ, 0, 0, 0, 0);
		// bad sizes, then the largest table
		queue_edit(ACT_SET_SIZE, 0, 0, 0, 0);
		queue_edit(ACT_SET_SIZE, 0, 0, 9, 0);
		queue_edit(ACT_SET_SIZE, 15, 15, 15, 0);
		queue_edit(ACT_SET_SIZE, 0, 0, 8, 0);
		queue_edit(ACT_WRITE, 7, 7, 0, 32'h7fff_ffff);
		queue_edit(ACT_WRITE, 0, 0, 0, 32'h8000_0000);
		queue_edit(ACT_WRITE, 15, 15, 0, 32'hffff_ffff);
		queue_edit(ACT_READ, 7, 7, 0, 0);
		// full table refuses inserts; past-the-end index is out of range
		queue_edit(ACT_INS_ROW, 8, 0, 0, 0);
		queue_edit(ACT_INS_COL, 0, 9, 0, 0);
		queue_edit(ACT_INS_COL, 0, 8, 0, 0);
		// shifts: the corner cell moves up and left
		queue_edit(ACT_DEL_ROW, 0, 0, 0, 0);
		queue_edit(ACT_DEL_COL, 0, 0, 0, 0);
		queue_edit(ACT_READ, 6, 6, 0, 0);
		queue_edit(ACT_INS_ROW, 2, 0, 0, 32'hffff_ffff);
		queue_edit(ACT_INS_COL, 0, 7, 0, 32'h5a5a_5a5a);
		queue_edit(ACT_READ, 2, 3, 0, 0);
		queue_edit(OP_UNDEFINED, 15, 15, 15, 32'hffff_ffff);

		// random part, steered by a count-only shadow so most indices land in range
		queue_edit(ACT_SET_SIZE, 0, 0, 4, 0);
		g_rows = 4;
		g_cols = 4;
		for (n = 0; n < RANDOM_EDITS; n++) begin
			pick = $urandom_range(99);
			row = IDX_W'($urandom_range(15));
			col = IDX_W'($urandom_range(15));
			size = IDX_W'(($urandom_range(4) != 0) ? $urandom_range(1, 8) :
				$urandom_range(15));
			if (pick < 6) op = ACT_SET_SIZE;
			else if (pick < 30) op = ACT_WRITE;
			else if (pick < 54) op = ACT_READ;
			else if (pick < 63) op = ACT_DEL_ROW;
			else if (pick < 72) op = ACT_DEL_COL;
			else if (pick < 84) op = ACT_INS_ROW;
			else if (pick < 96) op = ACT_INS_COL;
			else if (pick < 98) op = OP_UNDEFINED;
			else op = ACTION_W'($urandom_range(7));
			if ((g_rows == 0 || g_cols == 0) && $urandom_range(3) == 0)
				op = ACT_SET_SIZE;
			if ($urandom_range(9) < 8) begin
				if (op == ACT_INS_ROW || op == ACT_INS_COL) begin
					row = IDX_W'($urandom_range(g_rows));
					col = IDX_W'($urandom_range(g_cols));
				end else begin
					if (g_rows != 0)
						row = IDX_W'($urandom_range(g_rows - 1));
					if (g_cols != 0)
						col = IDX_W'($urandom_range(g_cols - 1));
				end
			end
			queue_edit(op, row, col, size, $urandom);
			case (op)
				ACT_SET_SIZE: if (size >= 1 && size <= GRID_DIM) begin
					g_rows = int'(size);
					g_cols = int'(size);
				end
				ACT_DEL_ROW: if (row < g_rows) g_rows--;
				ACT_DEL_COL: if (col < g_cols) g_cols--;
				ACT_INS_ROW: if (row <= g_rows && g_rows < GRID_DIM) g_rows++;
				ACT_INS_COL: if (col <= g_cols && g_cols < GRID_DIM) g_cols++;
				default: ;
			endcase
		end

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// sampled mid-cycle so the driver and monitor have settled
		do
			@(negedge clk);
		while (pending_edits.size() != 0 || s_tvalid || expected_replies.size() != 0);
		repeat (10) @(posedge clk);
		if (mismatches == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

	// Watchdog
	initial begin
		#400_000;
		$display("status: fail");
		$finish;
	end

endmodule

/* filelist.f */
src/mrce_pkg.sv
src/mrce_core.sv
src/matrix_row_column_editor_unit.sv
tb/tb_top.sv
